// File: design/psmf_pkg.sv
// ----------------------------------------------------------------------------
// psmf_pkg
// Shared constants, types and the saturation helper of the position
// sliding-mode force controller.
// ----------------------------------------------------------------------------
`default_nettype none

package psmf_pkg;

    localparam int NUM_LANES  = 3;
    localparam int NUM_STAGES = 10;
    localparam int LANE_W     = 16;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int CFG_W      = NUM_LANES * LANE_W;

    localparam logic [LANE_W-1:0] MASS_RESET     = 16'd256;
    localparam logic [LANE_W-1:0] INV_MASS_RESET = 16'd4096;

    typedef enum logic [2:0] {
        REG_SURFACE_SLOPE   = 3'd0,
        REG_SWITCHING_GAIN  = 3'd1,
        REG_INV_BOUNDARY    = 3'd2,
        REG_ACCEL_LIMIT     = 3'd3,
        REG_GRAVITY         = 3'd4,
        REG_VEHICLE_MASS    = 3'd5,
        REG_INV_MASS        = 3'd6,
        REG_UNUSED          = 3'd7
    } psmf_reg_t;

    // Per-stage load enables from the pipeline control to every lane.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } psmf_ctl_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
        begin
            return hi[WORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[WORD_W-1:0];
        end
        else
        begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage : psmf_pkg

`default_nettype wire

// File: design/psmf_ctrl.sv
// ----------------------------------------------------------------------------
// psmf_ctrl
// Valid tracking of the lane pipeline; a stage loads whenever it is empty
// or its word moves on, so bubbles collapse under back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module psmf_ctrl
    import psmf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output psmf_ctl_t      ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign ctl.load  = adv;

endmodule : psmf_ctrl

`default_nettype wire

// File: design/psmf_lane.sv
// ----------------------------------------------------------------------------
// psmf_lane
// One axis of the controller: ten register stages from the errors to the
// saturated force, with at most one multiplier rank between registers.
// ----------------------------------------------------------------------------
`default_nettype none

module psmf_lane
    import psmf_pkg::*;
(
    input  wire logic                     clk,
    input  wire psmf_ctl_t                ctl,
    input  wire logic signed [WORD_W-1:0] pos,
    input  wire logic signed [WORD_W-1:0] vel,
    input  wire logic signed [WORD_W-1:0] ref_pos,
    input  wire logic signed [WORD_W-1:0] ref_vel,
    input  wire logic [LANE_W-1:0]        lambda,
    input  wire logic [LANE_W-1:0]        kappa,
    input  wire logic [LANE_W-1:0]        inv_bound,
    input  wire logic [LANE_W-1:0]        acc_lim,
    input  wire logic [LANE_W-1:0]        grav,
    input  wire logic [LANE_W-1:0]        mass,
    input  wire logic [LANE_W-1:0]        inv_mass,
    output logic signed [WORD_W-1:0]      force_out
);

    // Stage 0: errors and lambda*kappa.
    logic signed [WORD_W-1:0] ep0_reg, ev0_reg;
    logic [2*LANE_W-1:0]      kp0_reg;
    // Stage 1: first products.
    logic signed [48:0]       lamep1_reg, kapev1_reg;
    logic signed [63:0]       kpep1_reg;
    logic signed [WORD_W-1:0] ev1_reg;
    // Stage 2: sliding surface.
    logic signed [WORD_W-1:0] s2_reg;
    logic signed [48:0]       kapev2_reg;
    logic signed [63:0]       kpep2_reg;
    // Stage 3: surface scaled by the boundary reciprocal.
    logic signed [48:0]       sib3_reg, kapev3_reg;
    logic signed [63:0]       kpep3_reg;
    // Stage 4: kappa times the clamped boundary term.
    logic signed [34:0]       kapsat4_reg;
    logic signed [48:0]       kapev4_reg;
    logic signed [63:0]       kpep4_reg;
    // Stage 5..9.
    logic signed [WORD_W-1:0] num5_reg;
    logic signed [48:0]       numinv6_reg;
    logic signed [26:0]       acc7_reg;
    logic signed [43:0]       ma8_reg;
    logic signed [WORD_W-1:0] force9_reg;

    logic signed [WORD_W-1:0] ep_next, ev_next, s_next, num_next, force_next;
    logic signed [17:0]       bsat;
    logic signed [63:0]       t_sib, t_num, t_acc, t_neg;
    logic signed [WORD_W-1:0] acc_sat, acc_clip, lim_pos, lim_neg, grav_ext, acc_sum;

    always_comb
    begin
        ep_next = sat32(64'(pos) - 64'(ref_pos));
        ev_next = sat32(64'(vel) - 64'(ref_vel));
        s_next  = sat32(64'(ev1_reg) + (64'(lamep1_reg) >>> 8));

        t_sib = 64'(sib3_reg) >>> 8;
        if (t_sib > 64'sd65536)
        begin
            bsat = 18'sd65536;
        end
        else if (t_sib < -64'sd65536)
        begin
            bsat = -18'sd65536;
        end
        else
        begin
            bsat = t_sib[17:0];
        end

        t_num = (kpep4_reg >>> 16) + (64'(kapev4_reg) >>> 8) + (64'(kapsat4_reg) >>> 8);
        num_next = sat32(t_num);

        // Acceleration: saturate, clip to the symmetric limit, then add gravity.
        t_acc    = 64'(numinv6_reg) >>> 12;
        acc_sat  = sat32(t_acc);
        lim_pos  = $signed({8'd0, acc_lim, 8'd0});
        lim_neg  = -lim_pos;
        grav_ext = $signed({{8{grav[LANE_W-1]}}, grav, 8'd0});
        if (acc_sat < lim_neg)
        begin
            acc_clip = lim_neg;
        end
        else if (acc_sat > lim_pos)
        begin
            acc_clip = lim_pos;
        end
        else
        begin
            acc_clip = acc_sat;
        end
        acc_sum = acc_clip + grav_ext;

        t_neg      = -(64'(ma8_reg) >>> 8);
        force_next = sat32(t_neg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            ep0_reg <= ep_next;
            ev0_reg <= ev_next;
            kp0_reg <= lambda * kappa;
        end
        if (ctl.load[1])
        begin
            lamep1_reg <= $signed({1'b0, lambda}) * ep0_reg;
            kapev1_reg <= $signed({1'b0, kappa}) * ev0_reg;
            kpep1_reg  <= $signed({1'b0, kp0_reg}) * ep0_reg;
            ev1_reg    <= ev0_reg;
        end
        if (ctl.load[2])
        begin
            s2_reg     <= s_next;
            kapev2_reg <= kapev1_reg;
            kpep2_reg  <= kpep1_reg;
        end
        if (ctl.load[3])
        begin
            sib3_reg   <= s2_reg * $signed({1'b0, inv_bound});
            kapev3_reg <= kapev2_reg;
            kpep3_reg  <= kpep2_reg;
        end
        if (ctl.load[4])
        begin
            kapsat4_reg <= $signed({1'b0, kappa}) * bsat;
            kapev4_reg  <= kapev3_reg;
            kpep4_reg   <= kpep3_reg;
        end
        if (ctl.load[5])
        begin
            num5_reg <= num_next;
        end
        if (ctl.load[6])
        begin
            numinv6_reg <= num5_reg * $signed({1'b0, inv_mass});
        end
        if (ctl.load[7])
        begin
            acc7_reg <= acc_sum[26:0];
        end
        if (ctl.load[8])
        begin
            ma8_reg <= $signed({1'b0, mass}) * acc7_reg;
        end
        if (ctl.load[9])
        begin
            force9_reg <= force_next;
        end
    end

    assign force_out = force9_reg;

endmodule : psmf_lane

`default_nettype wire

// File: design/position_sliding_mode_force_top.sv
// ----------------------------------------------------------------------------
// position_sliding_mode_force_top
// Three-axis sliding-mode position controller with a boundary layer.
// ----------------------------------------------------------------------------
// Each input word carries position, velocity and their references for three
// axes in Q16.16; each output word carries the saturated force per axis. One
// lane per axis runs a ten-stage pipeline, so a word is accepted every cycle
// while the pipeline has room; the output stage holds a result while the
// consumer stalls and the earlier stages keep filling their bubbles.
// Registers sit on an APB port at byte addresses 8*i; the user must write
// them only while no word is in flight, which the block does not enforce.
`default_nettype none

module position_sliding_mode_force_top
    import psmf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [WORD_W-1:0] pos_x,
    input  wire logic signed [WORD_W-1:0] pos_y,
    input  wire logic signed [WORD_W-1:0] pos_z,
    input  wire logic signed [WORD_W-1:0] vel_x,
    input  wire logic signed [WORD_W-1:0] vel_y,
    input  wire logic signed [WORD_W-1:0] vel_z,
    input  wire logic signed [WORD_W-1:0] ref_pos_x,
    input  wire logic signed [WORD_W-1:0] ref_pos_y,
    input  wire logic signed [WORD_W-1:0] ref_pos_z,
    input  wire logic signed [WORD_W-1:0] ref_vel_x,
    input  wire logic signed [WORD_W-1:0] ref_vel_y,
    input  wire logic signed [WORD_W-1:0] ref_vel_z,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [WORD_W-1:0]      force_x,
    output logic signed [WORD_W-1:0]      force_y,
    output logic signed [WORD_W-1:0]      force_z
);

    logic [CFG_W-1:0]  slope_reg, gain_reg, inv_bound_reg, limit_reg, grav_reg;
    logic [LANE_W-1:0] mass_reg, inv_mass_reg;
    logic              wr_en;
    psmf_reg_t         reg_sel;
    psmf_ctl_t         ctl;

    logic signed [WORD_W-1:0] pos_v     [NUM_LANES];
    logic signed [WORD_W-1:0] vel_v     [NUM_LANES];
    logic signed [WORD_W-1:0] ref_pos_v [NUM_LANES];
    logic signed [WORD_W-1:0] ref_vel_v [NUM_LANES];
    logic signed [WORD_W-1:0] force_v   [NUM_LANES];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = psmf_reg_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg     <= '0;
            gain_reg      <= '0;
            inv_bound_reg <= '0;
            limit_reg     <= '0;
            grav_reg      <= '0;
            mass_reg      <= MASS_RESET;
            inv_mass_reg  <= INV_MASS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_SURFACE_SLOPE:  slope_reg     <= pwdata[CFG_W-1:0];
                REG_SWITCHING_GAIN: gain_reg      <= pwdata[CFG_W-1:0];
                REG_INV_BOUNDARY:   inv_bound_reg <= pwdata[CFG_W-1:0];
                REG_ACCEL_LIMIT:    limit_reg     <= pwdata[CFG_W-1:0];
                REG_GRAVITY:        grav_reg      <= pwdata[CFG_W-1:0];
                REG_VEHICLE_MASS:   mass_reg      <= pwdata[LANE_W-1:0];
                REG_INV_MASS:       inv_mass_reg  <= pwdata[LANE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SURFACE_SLOPE:  prdata = DATA_W'(slope_reg);
            REG_SWITCHING_GAIN: prdata = DATA_W'(gain_reg);
            REG_INV_BOUNDARY:   prdata = DATA_W'(inv_bound_reg);
            REG_ACCEL_LIMIT:    prdata = DATA_W'(limit_reg);
            REG_GRAVITY:        prdata = DATA_W'(grav_reg);
            REG_VEHICLE_MASS:   prdata = DATA_W'(mass_reg);
            REG_INV_MASS:       prdata = DATA_W'(inv_mass_reg);
            default:            prdata = '0;
        endcase
    end

    psmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    assign pos_v     = '{pos_x, pos_y, pos_z};
    assign vel_v     = '{vel_x, vel_y, vel_z};
    assign ref_pos_v = '{ref_pos_x, ref_pos_y, ref_pos_z};
    assign ref_vel_v = '{ref_vel_x, ref_vel_y, ref_vel_z};

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        psmf_lane u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .pos       (pos_v[i]),
            .vel       (vel_v[i]),
            .ref_pos   (ref_pos_v[i]),
            .ref_vel   (ref_vel_v[i]),
            .lambda    (slope_reg[i*LANE_W +: LANE_W]),
            .kappa     (gain_reg[i*LANE_W +: LANE_W]),
            .inv_bound (inv_bound_reg[i*LANE_W +: LANE_W]),
            .acc_lim   (limit_reg[i*LANE_W +: LANE_W]),
            .grav      (grav_reg[i*LANE_W +: LANE_W]),
            .mass      (mass_reg),
            .inv_mass  (inv_mass_reg),
            .force_out (force_v[i])
        );
    end

    // The lanes' output stages together form the result word.
    assign force_x = force_v[0];
    assign force_y = force_v[1];
    assign force_z = force_v[2];

endmodule : position_sliding_mode_force_top

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis sliding-mode force controller.
// A short table of directed words runs under fixed register presets. Then
// several phases of random words follow, each under random settings. Every
// accepted word is scored against a table value or a bit-accurate force predictor. Both
// handshakes idle at random, except in one phase that runs without gaps.
// ----------------------------------------------------------------------------
module tb_top import psmf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_PCT      = 35;
    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     DRAIN_CYCLES  = NUM_STAGES + 4;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_WORDS   = 75;
    localparam int     STEADY_PHASE  = 2;
    localparam int     PAUSE_PHASE   = 3;
    localparam int     PRINT_CAP     = 100;
    localparam longint WORD_MAX      = 64'sd2147483647;
    localparam longint WORD_MIN      = -64'sd2147483648;
    localparam longint ONE_Q16       = 64'sd65536;

    localparam logic [WORD_W-1:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;

    typedef logic [NUM_LANES-1:0][WORD_W-1:0] triple_t;

    typedef struct packed {
        triple_t pos;
        triple_t vel;
        triple_t rpos;
        triple_t rvel;
    } sample_t;

    typedef struct {
        int      preset_id;
        sample_t smp;
        bit      typed;
        triple_t want;
    } stim_row_t;

    typedef logic [DATA_W-1:0] reg_image_t [8];

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] vel_z;
    logic signed [WORD_W-1:0] ref_pos_x;
    logic signed [WORD_W-1:0] ref_pos_y;
    logic signed [WORD_W-1:0] ref_pos_z;
    logic signed [WORD_W-1:0] ref_vel_x;
    logic signed [WORD_W-1:0] ref_vel_y;
    logic signed [WORD_W-1:0] ref_vel_z;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] force_x;
    logic signed [WORD_W-1:0] force_y;
    logic signed [WORD_W-1:0] force_z;

    // Shadow copy of the register file, updated as each write completes.
    logic [CFG_W-1:0]  slope_r    = '0;
    logic [CFG_W-1:0]  gain_r     = '0;
    logic [CFG_W-1:0]  inv_bw_r   = '0;
    logic [CFG_W-1:0]  acc_lim_r  = '0;
    logic [CFG_W-1:0]  grav_r     = '0;
    logic [LANE_W-1:0] mass_r     = MASS_RESET;
    logic [LANE_W-1:0] inv_mass_r = INV_MASS_RESET;

    triple_t   expected_forces [$];
    stim_row_t dir_table [$];
    bit        steady      = 1'b0;
    int        mismatches  = 0;
    int        words_seen  = 0;
    int        cycle_count = 0;

    position_sliding_mode_force_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .ref_pos_x (ref_pos_x),
        .ref_pos_y (ref_pos_y),
        .ref_pos_z (ref_pos_z),
        .ref_vel_x (ref_vel_x),
        .ref_vel_y (ref_vel_y),
        .ref_vel_z (ref_vel_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .force_x   (force_x),
        .force_y   (force_y),
        .force_z   (force_z)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic longint clip32(longint v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        else if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic void store_reg(psmf_reg_t r, logic [DATA_W-1:0] v);
        case (r)
            REG_SURFACE_SLOPE:  slope_r    = v[CFG_W-1:0];
            REG_SWITCHING_GAIN: gain_r     = v[CFG_W-1:0];
            REG_INV_BOUNDARY:   inv_bw_r   = v[CFG_W-1:0];
            REG_ACCEL_LIMIT:    acc_lim_r  = v[CFG_W-1:0];
            REG_GRAVITY:        grav_r     = v[CFG_W-1:0];
            REG_VEHICLE_MASS:   mass_r     = v[LANE_W-1:0];
            REG_INV_MASS:       inv_mass_r = v[LANE_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] axis_force(int i, sample_t s);
        longint lam;
        longint kap;
        longint ib;
        longint lim;
        longint g;
        longint ep;
        longint ev;
        longint surf;
        longint blayer;
        longint num;
        longint acc;
        longint f;
        lam = longint'(slope_r[LANE_W*i +: LANE_W]);
        kap = longint'(gain_r[LANE_W*i +: LANE_W]);
        ib  = longint'(inv_bw_r[LANE_W*i +: LANE_W]);
        lim = longint'(acc_lim_r[LANE_W*i +: LANE_W]) * 256;
        g   = longint'($signed(grav_r[LANE_W*i +: LANE_W])) * 256;
        ep  = clip32(longint'($signed(s.pos[i])) - longint'($signed(s.rpos[i])));
        ev  = clip32(longint'($signed(s.vel[i])) - longint'($signed(s.rvel[i])));
        surf = clip32(ev + ((lam * ep) >>> 8));
        // The boundary layer term is limited to plus or minus one in Q16.16.
        blayer = (surf * ib) >>> 8;
        if (blayer > ONE_Q16)
        begin
            blayer = ONE_Q16;
        end
        if (blayer < -ONE_Q16)
        begin
            blayer = -ONE_Q16;
        end
        num = clip32((((lam * kap) * ep) >>> 16) + ((kap * ev) >>> 8) + ((kap * blayer) >>> 8));
        acc = clip32((num * longint'(inv_mass_r)) >>> 12);
        if (acc < -lim)
        begin
            acc = -lim;
        end
        if (acc > lim)
        begin
            acc = lim;
        end
        acc = acc + g;
        f = clip32(-((longint'(mass_r) * acc) >>> 8));
        return f[WORD_W-1:0];
    endfunction

    function automatic triple_t predict_forces(sample_t s);
        triple_t t;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            t[i] = axis_force(i, s);
        end
        return t;
    endfunction

    function automatic stim_row_t vec(int preset_id, logic [WORD_W-1:0] p, logic [WORD_W-1:0] v,
                                      logic [WORD_W-1:0] rp, logic [WORD_W-1:0] rv,
                                      bit typed, triple_t want);
        stim_row_t row;
        row.preset_id = preset_id;
        row.smp.pos   = {NUM_LANES{p}};
        row.smp.vel   = {NUM_LANES{v}};
        row.smp.rpos  = {NUM_LANES{rp}};
        row.smp.rvel  = {NUM_LANES{rv}};
        row.typed     = typed;
        row.want      = want;
        return row;
    endfunction

    // Register images for the directed part, listed in register order; the
    // last entry goes to the unused address and must change nothing. Some
    // images carry junk above the register width on purpose.
    function automatic reg_image_t preset(int preset_id);
        case (preset_id)
            1:
            begin
                // Zero acceleration limit: only gravity reaches the output.
                return '{64'hA5A5_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
                         64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_0000_0000_0000,
                         64'h0000_7FFF_FF00_0100, 64'h1234_5678_9ABC_0100,
                         64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
            end
            2:
            begin
                return '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'h0000_8000_8000_8000, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0000};
            end
            3:
            begin
                // Both reciprocals zero: the acceleration is gravity alone.
                return '{64'h0000_0300_0200_0100, 64'h0000_0100_0200_0300,
                         64'h0000_0000_0000_0000, 64'h0000_FFFF_FFFF_FFFF,
                         64'h0000_FF80_0000_0100, 64'h0000_0000_0000_0200,
                         64'h0000_0000_0000_0000, 64'h0123_4567_89AB_CDEF};
            end
            default:
            begin
                // Moderate gains; the x lane has no boundary reciprocal.
                return '{64'h0000_0200_0200_0200, 64'h0000_0180_0180_0180,
                         64'h0000_4000_0100_0000, 64'h0000_0A00_0A00_0A00,
                         64'h0000_F631_0000_0000, 64'h0000_0000_0000_0180,
                         64'h0000_0000_0000_0AAB, 64'h0000_0000_0000_0007};
            end
        endcase
    endfunction

    function automatic logic [LANE_W-1:0] pick_lane();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 16'h0400));
        endcase
    endfunction

    function automatic logic [LANE_W-1:0] pick_gravity();
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 16'h1800)) - 16'h0C00;
    endfunction

    function automatic reg_image_t random_image();
        reg_image_t img;
        img[REG_SURFACE_SLOPE]  = {16'($urandom), pick_lane(), pick_lane(), pick_lane()};
        img[REG_SWITCHING_GAIN] = {16'($urandom), pick_lane(), pick_lane(), pick_lane()};
        img[REG_INV_BOUNDARY]   = {16'($urandom), pick_lane(), pick_lane(), pick_lane()};
        img[REG_ACCEL_LIMIT]    = {16'($urandom), pick_lane(), pick_lane(), pick_lane()};
        img[REG_GRAVITY]        = {16'($urandom), pick_gravity(), pick_gravity(), pick_gravity()};
        img[REG_VEHICLE_MASS]   = {16'($urandom), 32'($urandom),
                                   ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                                   16'($urandom_range(16'h0040, 16'h0800))};
        img[REG_INV_MASS]       = {16'($urandom), 32'($urandom), pick_lane()};
        img[REG_UNUSED]         = {$urandom, $urandom};
        return img;
    endfunction

    // Mostly small errors around a random operating point, so that the
    // boundary layer and the limits are reached without saturating.
    function automatic sample_t random_sample();
        sample_t s;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            s.pos[i] = $urandom;
            s.vel[i] = $urandom;
            if ($urandom_range(0, 99) < 70)
            begin
                s.rpos[i] = s.pos[i] - (32'($urandom_range(0, 1 << 19)) - 32'(1 << 18));
                s.rvel[i] = s.vel[i] - (32'($urandom_range(0, 1 << 19)) - 32'(1 << 18));
            end
            else
            begin
                s.rpos[i] = $urandom;
                s.rvel[i] = $urandom;
            end
        end
        return s;
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic drive_sample(sample_t s);
        pos_x     = s.pos[0];
        pos_y     = s.pos[1];
        pos_z     = s.pos[2];
        vel_x     = s.vel[0];
        vel_y     = s.vel[1];
        vel_z     = s.vel[2];
        ref_pos_x = s.rpos[0];
        ref_pos_y = s.rpos[1];
        ref_pos_z = s.rpos[2];
        ref_vel_x = s.rvel[0];
        ref_vel_y = s.rvel[1];
        ref_vel_z = s.rvel[2];
    endtask

    task automatic write_reg(psmf_reg_t r, logic [DATA_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(8 * int'(r));
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        store_reg(r, v);
    endtask

    task automatic load_settings(reg_image_t img);
        psmf_reg_t r;
        r = r.first();
        do
        begin
            write_reg(r, img[r]);
            r = r.next();
        end
        while (r != r.first());
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_forces.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(sample_t s, bit typed, triple_t want);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        drive_sample(s);
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_forces.push_back(typed ? want : predict_forces(s));
    endtask

    always @(negedge clk)
    begin
        out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : rx_check
        triple_t got;
        triple_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {force_z, force_y, force_x};
            if (expected_forces.size() == 0)
            begin
                note_mismatch($sformatf("word %0d arrived with nothing pending: %h",
                                        words_seen, got));
            end
            else
            begin
                want = expected_forces.pop_front();
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        note_mismatch($sformatf("word %0d axis %0d force got %h expected %h",
                                                words_seen, i, got[i], want[i]));
                    end
                end
            end
            words_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int      cur_preset;
        triple_t zero3;
        triple_t gravity_only;
        triple_t no_recip;
        zero3        = '0;
        gravity_only = {32'hFF80_0100, 32'h0001_0000, 32'hFFFF_0000};
        no_recip     = {32'h0001_0000, 32'h0000_0000, 32'hFFFE_0000};
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        drive_sample('0);

        // Reset settings: zero limit and zero gravity force every output to zero.
        dir_table.push_back(vec(0, 0, 0, 0, 0, 1, zero3));
        dir_table.push_back(vec(0, W_MAX, W_MIN, W_MIN, W_MAX, 1, zero3));
        dir_table.push_back(vec(0, W_MIN, W_MAX, W_MAX, W_MIN, 1, zero3));
        dir_table.push_back(vec(0, 32'h0001_0000, 32'hFFFF_8000, 0, 0, 1, zero3));
        dir_table.push_back(vec(1, 0, 0, 0, 0, 1, gravity_only));
        dir_table.push_back(vec(1, W_MAX, W_MAX, W_MIN, W_MIN, 1, gravity_only));
        dir_table.push_back(vec(1, W_MIN, W_MIN, W_MAX, W_MAX, 1, gravity_only));
        dir_table.push_back(vec(1, 32'h0012_3456, 32'h8000_0001, 32'h7FFF_FFFE, 1, 1,
                                gravity_only));
        dir_table.push_back(vec(2, 0, 0, 0, 0, 0, zero3));
        dir_table.push_back(vec(2, W_MAX, W_MAX, W_MIN, W_MIN, 0, zero3));
        dir_table.push_back(vec(2, W_MIN, W_MIN, W_MAX, W_MAX, 0, zero3));
        dir_table.push_back(vec(2, 32'h0000_0100, 0, 0, 32'h0000_0080, 0, zero3));
        dir_table.push_back(vec(2, 32'hFFFF_FF00, 32'h0000_007F, 0, 0, 0, zero3));
        dir_table.push_back(vec(3, 0, 0, 0, 0, 1, no_recip));
        dir_table.push_back(vec(3, W_MAX, W_MIN, W_MIN, W_MAX, 1, no_recip));
        dir_table.push_back(vec(3, 32'h0003_0000, 32'hFFFE_0000, 0, 0, 1, no_recip));
        dir_table.push_back(vec(4, 32'h0000_8000, 0, 0, 0, 0, zero3));
        dir_table.push_back(vec(4, 0, 32'h0000_4000, 0, 0, 0, zero3));
        dir_table.push_back(vec(4, 32'hFFFF_0000, 32'h0002_0000, 0, 0, 0, zero3));
        dir_table.push_back(vec(4, 32'h0010_0000, 0, 0, 32'h0008_0000, 0, zero3));
        dir_table.push_back(vec(4, 0, 0, 32'h0000_0100, 32'hFFFF_FF00, 0, zero3));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cur_preset = 0;
        foreach (dir_table[k])
        begin
            if (dir_table[k].preset_id != cur_preset)
            begin
                wait_drained();
                load_settings(preset(dir_table[k].preset_id));
                cur_preset = dir_table[k].preset_id;
            end
            send_word(dir_table[k].smp, dir_table[k].typed, dir_table[k].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            load_settings(random_image());
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Hold off once mid-phase until every pending word is back.
                if (ph == PAUSE_PHASE && n == PHASE_WORDS / 2)
                begin
                    wait_drained();
                end
                send_word(random_sample(), 1'b0, zero3);
            end
        end
        steady = 1'b0;
        wait_drained();

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: position_sliding_mode_force_top.f
design/psmf_pkg.sv
design/psmf_ctrl.sv
design/psmf_lane.sv
design/position_sliding_mode_force_top.sv
bench/tb_top.sv
